// ===== hw/rtl/mbrsp_pkg.sv =====
// Package for the Modbus function-03 response frame parser.
// Frame constants, status codes, the controller state type and register map.
// No dependencies.
`timescale 1ns / 1ps

package mbrsp_pkg;

   // Default number of channel readings kept per frame
   localparam int MAX_CHANNELS_DEF = 7;

   // CRC-16 (Modbus): reflected polynomial, all-ones start
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Frame layout
   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [8:0] POS_MAX           = 9'd511;
   localparam logic [8:0] MIN_FRAME_LEN     = 9'd5;
   localparam logic [8:0] FRAME_OVERHEAD    = 9'd5;

   // Reading classification
   localparam logic [15:0] DIST_LIMIT    = 16'hFFF0;
   localparam logic [15:0] DIST_OVERLOAD = 16'h0000;

   // Register map
   localparam int          CSR_ADDR_W        = 3;
   localparam logic [2:0]  CSR_EXPECTED_ADDR = 3'h0;
   localparam logic [7:0]  EXPECTED_ADDR_RST = 8'h01;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_SHORT = 3'd1,
      STATUS_ADDR  = 3'd2,
      STATUS_FUNC  = 3'd3,
      STATUS_LEN   = 3'd4,
      STATUS_CRC   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIN,
      S_LOAD
   } state_type;

endpackage

// ===== hw/rtl/mbrsp_if.sv =====
// Request and response channel interfaces of the frame parser.
// Depends on mbrsp_pkg for the status type.
`timescale 1ns / 1ps

// One received byte per request
interface mbrsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_frame;

   modport source (output valid, output rx_byte, output end_of_frame, input ready);
   modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

// One frame result or channel reading per request
interface mbrsp_rsp_if;
   logic                 valid;
   logic                 ready;
   mbrsp_pkg::status_type frame_status;
   logic                 has_channel;
   logic [2:0]           channel_index;
   logic [15:0]          reading_mm;
   logic                 reading_valid;
   logic                 overload;
   logic                 reading_invalid;
   logic                 last_result;

   modport source (output valid, output frame_status, output has_channel,
                   output channel_index, output reading_mm, output reading_valid,
                   output overload, output reading_invalid, output last_result,
                   input ready);
   modport sink   (input valid, input frame_status, input has_channel,
                   input channel_index, input reading_mm, input reading_valid,
                   input overload, input reading_invalid, input last_result,
                   output ready);
endinterface

// ===== hw/rtl/modbus_response_frame_parser_top.sv =====
// Modbus RTU function-03 response frame parser, top level.
// Depends on mbrsp_pkg, mbrsp_if (channel interfaces) and mbrsp_ram.
//
//   port      dir   handshake             carries
//   req_bus   in    valid/ready           rx_byte, end_of_frame
//   rsp_bus   out   valid/ready           frame status and one channel reading
//   APB       in    psel/penable/pready   expected_address at byte address 0
//
// A byte is taken while the controller is idle and no frame result is being read
// out; reading bytes go straight into the channel RAM. On the end-of-frame byte
// the checks run in that cycle and the verdict is latched; S_FIN then decides,
// and S_LOAD reads one result per cycle out of the channel RAM while the output
// register is free. The output register lets a new byte come in while the last
// result still waits. Synchronous reset clears frame state and sets
// expected_address to 1; the RAM needs no clearing.
`timescale 1ns / 1ps

module modbus_response_frame_parser_top #(
   parameter int MAX_CHANNELS = mbrsp_pkg::MAX_CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   mbrsp_req_if.sink                       req_bus,
   mbrsp_rsp_if.source                     rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mbrsp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int ChIdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CntW   = $clog2(MAX_CHANNELS + 1);
   localparam logic [7:0]      MaxCh8   = 8'(MAX_CHANNELS);
   localparam logic [CntW-1:0] MaxChCnt = CntW'(MAX_CHANNELS);

   // Byte-wise CRC-16 update, eight shift steps
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ mbrsp_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // ---------------- configuration port ----------------
   logic [7:0] exp_addr_ff;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr == mbrsp_pkg::CSR_EXPECTED_ADDR) ? {24'h0, exp_addr_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_addr_ff <= mbrsp_pkg::EXPECTED_ADDR_RST;
      end else if (csr_wr && paddr == mbrsp_pkg::CSR_EXPECTED_ADDR) begin
         exp_addr_ff <= pwdata[7:0];
      end
   end

   // ---------------- state ----------------
   mbrsp_pkg::state_type  state_ff, state_in;
   logic [8:0]            pos_ff, pos_in;
   logic [15:0]           crc_ff, crc_in;
   logic [7:0]            cnt_ff, cnt_in;
   mbrsp_pkg::status_type herr_ff, herr_in;
   logic [7:0]            hold_ff, hold_in;
   mbrsp_pkg::status_type fin_status_ff, fin_status_in;
   logic [CntW-1:0]       fin_count_ff, fin_count_in;
   logic [CntW-1:0]       rd_idx_ff, rd_idx_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   mbrsp_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic [2:0]            rsp_idx_ff, rsp_idx_in;
   logic [15:0]           rsp_dist_ff, rsp_dist_in;
   logic                  rsp_rv_ff, rsp_rv_in;
   logic                  rsp_ovl_ff, rsp_ovl_in;
   logic                  rsp_inv_ff, rsp_inv_in;
   logic                  rsp_last_ff, rsp_last_in;

   // RAM ports
   logic              ram_wr_en;
   logic [ChIdxW-1:0] ram_wr_addr;
   logic [15:0]       ram_wr_data;
   logic              ram_rd_en;
   logic [ChIdxW-1:0] ram_rd_addr;
   logic [15:0]       ram_rd_data;

   logic req_fire;
   logic slot_free;
   logic load_err;
   logic load_ch;

   // per-byte next values before the end-of-frame clear
   logic [8:0]            pos_step;
   logic [15:0]           crc_step;
   logic [7:0]            cnt_step;
   mbrsp_pkg::status_type herr_step;
   logic [8:0]            rel;
   logic [7:0]            ch;
   logic [6:0]            half_cnt;
   mbrsp_pkg::status_type status_calc;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign rel       = pos_ff - 9'd3;
   assign ch        = rel[8:1];
   assign crc_step  = crc_update(crc_ff, req_bus.rx_byte);
   assign pos_step  = (pos_ff < mbrsp_pkg::POS_MAX) ? pos_ff + 9'd1 : pos_ff;
   assign half_cnt  = cnt_step[7:1];

   // Header capture and reading assembly for the byte at hand
   always_comb begin
      herr_step   = herr_ff;
      cnt_step    = cnt_ff;
      hold_in     = hold_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ch[ChIdxW-1:0];
      ram_wr_data = {hold_ff, req_bus.rx_byte};
      if (req_fire) begin
         if (pos_ff == 9'd0) begin
            if (req_bus.rx_byte != exp_addr_ff) begin
               herr_step = mbrsp_pkg::STATUS_ADDR;
            end
         end else if (pos_ff == 9'd1) begin
            if (req_bus.rx_byte != mbrsp_pkg::FUNC_READ_HOLDING &&
                herr_ff == mbrsp_pkg::STATUS_OK) begin
               herr_step = mbrsp_pkg::STATUS_FUNC;
            end
         end else if (pos_ff == 9'd2) begin
            cnt_step = req_bus.rx_byte;
         end else if (pos_ff < mbrsp_pkg::POS_MAX) begin
            if (!rel[0]) begin
               hold_in = req_bus.rx_byte;
            end else if (ch < MaxCh8) begin
               ram_wr_en = 1'b1;
            end
         end
      end
   end

   // Frame checks, in priority order
   always_comb begin
      if (pos_step < mbrsp_pkg::MIN_FRAME_LEN) begin
         status_calc = mbrsp_pkg::STATUS_SHORT;
      end else if (herr_step != mbrsp_pkg::STATUS_OK) begin
         status_calc = herr_step;
      end else if (pos_step != {1'b0, cnt_step} + mbrsp_pkg::FRAME_OVERHEAD) begin
         status_calc = mbrsp_pkg::STATUS_LEN;
      end else if (crc_step != 16'h0000) begin
         status_calc = mbrsp_pkg::STATUS_CRC;
      end else begin
         status_calc = mbrsp_pkg::STATUS_OK;
      end
   end

   // Frame state update; the end-of-frame byte latches the verdict and clears
   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      cnt_in        = cnt_ff;
      herr_in       = herr_ff;
      fin_status_in = fin_status_ff;
      fin_count_in  = fin_count_ff;
      if (req_fire) begin
         pos_in  = pos_step;
         crc_in  = crc_step;
         cnt_in  = cnt_step;
         herr_in = herr_step;
         if (req_bus.end_of_frame) begin
            fin_status_in = status_calc;
            fin_count_in  = ({1'b0, half_cnt} > MaxCh8) ? MaxChCnt : CntW'(half_cnt);
            pos_in        = 9'd0;
            crc_in        = mbrsp_pkg::CRC_INIT;
            cnt_in        = 8'h00;
            herr_in       = mbrsp_pkg::STATUS_OK;
         end
      end
   end

   // hold byte also clears at frame end
   logic [7:0] hold_next;
   assign hold_next = (req_fire && req_bus.end_of_frame) ? 8'h00 : hold_in;

   // Controller: next state, RAM reads and output loads
   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[ChIdxW-1:0];
      load_err    = 1'b0;
      load_ch     = 1'b0;
      req_bus.ready = 1'b0;
      unique case (state_ff)
         mbrsp_pkg::S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_fire && req_bus.end_of_frame) begin
               state_in = mbrsp_pkg::S_FIN;
            end
         end
         mbrsp_pkg::S_FIN: begin
            if (fin_status_ff != mbrsp_pkg::STATUS_OK || fin_count_ff == '0) begin
               if (slot_free) begin
                  load_err = 1'b1;
                  state_in = mbrsp_pkg::S_IDLE;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               rd_idx_in   = '0;
               state_in    = mbrsp_pkg::S_LOAD;
            end
         end
         mbrsp_pkg::S_LOAD: begin
            if (slot_free) begin
               load_ch = 1'b1;
               if (rd_idx_ff + CntW'(1) == fin_count_ff) begin
                  state_in = mbrsp_pkg::S_IDLE;
               end else begin
                  rd_idx_in   = rd_idx_ff + CntW'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rd_idx_in[ChIdxW-1:0];
               end
            end
         end
         default: begin
            state_in = mbrsp_pkg::S_IDLE;
         end
      endcase
   end

   // Output register payload
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_rv_in     = rsp_rv_ff;
      rsp_ovl_in    = rsp_ovl_ff;
      rsp_inv_in    = rsp_inv_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_err) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status_ff;
         rsp_has_in    = 1'b0;
         rsp_idx_in    = 3'd0;
         rsp_dist_in   = 16'h0000;
         rsp_rv_in     = 1'b0;
         rsp_ovl_in    = 1'b0;
         rsp_inv_in    = 1'b0;
         rsp_last_in   = 1'b1;
      end else if (load_ch) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = mbrsp_pkg::STATUS_OK;
         rsp_has_in    = 1'b1;
         rsp_idx_in    = 3'(rd_idx_ff);
         rsp_dist_in   = ram_rd_data;
         rsp_rv_in     = ram_rd_data < mbrsp_pkg::DIST_LIMIT;
         rsp_ovl_in    = ram_rd_data == mbrsp_pkg::DIST_OVERLOAD;
         rsp_inv_in    = ram_rd_data > mbrsp_pkg::DIST_LIMIT;
         rsp_last_in   = (rd_idx_ff + CntW'(1) == fin_count_ff);
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbrsp_pkg::S_IDLE;
         pos_ff       <= 9'd0;
         crc_ff       <= mbrsp_pkg::CRC_INIT;
         cnt_ff       <= 8'h00;
         herr_ff      <= mbrsp_pkg::STATUS_OK;
         hold_ff      <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         herr_ff      <= herr_in;
         hold_ff      <= hold_next;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_status_ff <= fin_status_in;
      fin_count_ff  <= fin_count_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_rv_ff     <= rsp_rv_in;
      rsp_ovl_ff    <= rsp_ovl_in;
      rsp_inv_ff    <= rsp_inv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.frame_status    = rsp_status_ff;
   assign rsp_bus.has_channel     = rsp_has_ff;
   assign rsp_bus.channel_index   = rsp_idx_ff;
   assign rsp_bus.reading_mm      = rsp_dist_ff;
   assign rsp_bus.reading_valid   = rsp_rv_ff;
   assign rsp_bus.overload        = rsp_ovl_ff;
   assign rsp_bus.reading_invalid = rsp_inv_ff;
   assign rsp_bus.last_result     = rsp_last_ff;

   // Channel reading store
   mbrsp_ram #(
      .WIDTH (16),
      .DEPTH (MAX_CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTH
   // frame state is back at its start after an end-of-frame byte
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.end_of_frame) |=>
         (pos_ff == 9'd0 && crc_ff == mbrsp_pkg::CRC_INIT && herr_ff == mbrsp_pkg::STATUS_OK))
      else $error("frame state not cleared after end of frame");

   // readout never runs past the reported count
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbrsp_pkg::S_LOAD) |-> (rd_idx_ff < fin_count_ff))
      else $error("channel readout index beyond count");

   // a reading only comes with an ok frame status
   a_chan_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_has_ff) |-> (rsp_status_ff == mbrsp_pkg::STATUS_OK))
      else $error("channel reading with error status");

   // a result without a reading closes its frame
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> rsp_last_ff)
      else $error("status-only result not marked last");
`endif

endmodule

// ===== hw/rtl/mbrsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbrsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 7,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
